// ----- design/rmq_pkg.sv -----
// rmq_pkg: shared constants, control struct and width helpers for the
// rotation matrix to quaternion unit; no dependencies
package rmq_pkg;

    localparam int RMQ_FRAC_BITS = 14;   // default fraction bits
    localparam int RMQ_IN_W      = 16;   // matrix element and quaternion width
    localparam int RMQ_NUM_W     = 17;   // width of a sum or difference of two elements
    localparam int RMQ_Q_MAX     = 32767;
    localparam int RMQ_Q_MIN_MAG = 32768;

    // branch select: largest diagonal element, or the trace branch
    localparam logic [1:0] SEL_I0    = 2'd0;
    localparam logic [1:0] SEL_I1    = 2'd1;
    localparam logic [1:0] SEL_I2    = 2'd2;
    localparam logic [1:0] SEL_TRACE = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] sel;
    } t_ctl;

    // width of the clamped radicand
    function automatic int f_rad_w(input int frac);
        return ((frac > RMQ_NUM_W) ? frac : RMQ_NUM_W) + 1;
    endfunction

    // width of the integer square root of radicand << frac
    function automatic int f_root_w(input int frac);
        return (f_rad_w(frac) + frac + 1) / 2;
    endfunction

endpackage

// ----- design/rmq_sqrt_pipe.sv -----
// rmq_sqrt_pipe: pipelined restoring square root, one root bit per stage,
// with the branch control and numerators riding along; uses rmq_pkg
module rmq_sqrt_pipe #(
    parameter int  FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
    localparam int RAD_W     = rmq_pkg::f_rad_w(FRAC_BITS),
    localparam int ROOT_W    = rmq_pkg::f_root_w(FRAC_BITS)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  rmq_pkg::t_ctl                             i_ctl,
    input  logic [RAD_W-1:0]                          i_rad,
    input  logic [2:0][rmq_pkg::RMQ_NUM_W-1:0]        i_num,
    output rmq_pkg::t_ctl                             o_ctl,
    output logic [ROOT_W-1:0]                         o_root,
    output logic [2:0][rmq_pkg::RMQ_NUM_W-1:0]        o_num
);
    import rmq_pkg::*;

    localparam int SQ_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    t_ctl                       a_ctl  [ROOT_W+1];
    logic [REM_W-1:0]           a_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]          a_root [ROOT_W+1];
    logic [SQ_W-1:0]            a_x    [ROOT_W+1];
    logic [2:0][RMQ_NUM_W-1:0]  a_num  [ROOT_W+1];

    assign a_ctl[0]  = i_ctl;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_x[0]    = SQ_W'(i_rad) << FRAC_BITS;
    assign a_num[0]  = i_num;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]          n_rem;
        logic [ROOT_W-1:0]         n_root;
        logic [REM_W-1:0]          rem_sh;
        logic [REM_W-1:0]          trial;
        logic                      ge;
        t_ctl                      r_ctl;
        logic [REM_W-1:0]          r_rem;
        logic [ROOT_W-1:0]         r_root;
        logic [SQ_W-1:0]           r_x;
        logic [2:0][RMQ_NUM_W-1:0] r_num;

        always_comb begin
            rem_sh = {a_rem[s][REM_W-3:0], a_x[s][SQ_W-1 -: 2]};
            trial  = {a_root[s], 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {a_root[s][ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= a_ctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_x    <= a_x[s] << 2;
                r_num  <= a_num[s];
            end
        end

        assign a_ctl[s+1]  = r_ctl;
        assign a_rem[s+1]  = r_rem;
        assign a_root[s+1] = r_root;
        assign a_x[s+1]    = r_x;
        assign a_num[s+1]  = r_num;
    end

    assign o_ctl  = a_ctl[ROOT_W];
    assign o_root = a_root[ROOT_W];
    assign o_num  = a_num[ROOT_W];

endmodule

// ----- design/rmq_div_pipe.sv -----
// rmq_div_pipe: three-lane pipelined restoring divider, (|num| << frac) / (2*root),
// one quotient bit per stage; uses rmq_pkg
module rmq_div_pipe #(
    parameter int  FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
    localparam int ROOT_W    = rmq_pkg::f_root_w(FRAC_BITS),
    localparam int QUO_W     = rmq_pkg::RMQ_NUM_W + FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  rmq_pkg::t_ctl                         i_ctl,
    input  logic [ROOT_W-1:0]                     i_root,
    input  logic [2:0][rmq_pkg::RMQ_NUM_W-1:0]    i_num,
    output rmq_pkg::t_ctl                         o_ctl,
    output logic [ROOT_W-1:0]                     o_root,
    output logic [2:0]                            o_neg,
    output logic [2:0][QUO_W-1:0]                 o_quo
);
    import rmq_pkg::*;

    localparam int DEN_W = ROOT_W + 1;
    localparam int REM_W = DEN_W + 1;

    t_ctl                   a_ctl  [QUO_W+1];
    logic [ROOT_W-1:0]      a_root [QUO_W+1];
    logic [2:0]             a_neg  [QUO_W+1];
    logic [2:0][QUO_W-1:0]  a_dq   [QUO_W+1];
    logic [2:0][DEN_W-1:0]  a_rem  [QUO_W+1];

    logic [2:0]                 in_neg;
    logic [2:0][RMQ_NUM_W-1:0]  in_mag;

    // sign and magnitude of each numerator
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            in_neg[l] = i_num[l][RMQ_NUM_W-1];
            in_mag[l] = in_neg[l] ? (~i_num[l] + 1'b1) : i_num[l];
        end
    end

    assign a_neg[0]  = in_neg;
    assign a_dq[0]   = {in_mag[2], {FRAC_BITS{1'b0}},
                        in_mag[1], {FRAC_BITS{1'b0}},
                        in_mag[0], {FRAC_BITS{1'b0}}};
    assign a_ctl[0]  = i_ctl;
    assign a_root[0] = i_root;
    assign a_rem[0]  = '0;

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [REM_W-1:0]       den;
        logic [2:0][REM_W-1:0]  rem_sh;
        logic [2:0]             ge;
        logic [2:0][DEN_W-1:0]  n_rem;
        logic [2:0][QUO_W-1:0]  n_dq;
        t_ctl                   r_ctl;
        logic [ROOT_W-1:0]      r_root;
        logic [2:0]             r_neg;
        logic [2:0][QUO_W-1:0]  r_dq;
        logic [2:0][DEN_W-1:0]  r_rem;

        always_comb begin
            den = {1'b0, a_root[s], 1'b0};
            for (int l = 0; l < 3; l++) begin
                rem_sh[l] = {a_rem[s][l], a_dq[s][l][QUO_W-1]};
                ge[l]     = (rem_sh[l] >= den);
                n_rem[l]  = ge[l] ? DEN_W'(rem_sh[l] - den) : DEN_W'(rem_sh[l]);
                n_dq[l]   = {a_dq[s][l][QUO_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= a_ctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= a_root[s];
                r_neg  <= a_neg[s];
                r_dq   <= n_dq;
                r_rem  <= n_rem;
            end
        end

        assign a_ctl[s+1]  = r_ctl;
        assign a_root[s+1] = r_root;
        assign a_neg[s+1]  = r_neg;
        assign a_dq[s+1]   = r_dq;
        assign a_rem[s+1]  = r_rem;
    end

    assign o_ctl  = a_ctl[QUO_W];
    assign o_root = a_root[QUO_W];
    assign o_neg  = a_neg[QUO_W];
    assign o_quo  = a_dq[QUO_W];

endmodule

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// rotation_matrix_to_quaternion_unit: 3x3 rotation matrix to unit quaternion
// (Shepperd's method) in signed fixed point; uses rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe
//
//  channel | direction | beat payload                       | handshake
//  --------+-----------+------------------------------------+------------------------
//  matrix  | in        | i_m00 .. i_m22, 16 bit signed each | i_valid / o_stall
//  quat    | out       | o_qx o_qy o_qz o_qw, 16 bit signed | o_valid / i_stall
//
// one beat per cycle in and out when nothing stalls; a beat passes stage 1, stage 2,
// the square root (one root bit per stage), the three dividers (one quotient bit per
// stage), the final stage and the output register
// synchronous active-low reset clears all valid bits; payload registers are not reset
// a held output beat parks in an output register, the next finished beat in a skid
// register; only a full skid register freezes the pipe and raises o_stall
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m00,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m01,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m02,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m10,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m11,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m12,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m20,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m21,
    input  logic signed [rmq_pkg::RMQ_IN_W-1:0]    i_m22,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [rmq_pkg::RMQ_IN_W-1:0]    o_qx,
    output logic signed [rmq_pkg::RMQ_IN_W-1:0]    o_qy,
    output logic signed [rmq_pkg::RMQ_IN_W-1:0]    o_qz,
    output logic signed [rmq_pkg::RMQ_IN_W-1:0]    o_qw
);
    import rmq_pkg::*;

    localparam int RAD_W  = f_rad_w(FRAC_BITS);
    localparam int ROOT_W = f_root_w(FRAC_BITS);
    localparam int QUO_W  = RMQ_NUM_W + FRAC_BITS;
    localparam int RS_W   = RAD_W + 1;          // signed radicand before the clamp
    localparam int TR_W   = RMQ_IN_W + 2;       // trace and three-term diagonal sums
    localparam int HALF_W = (ROOT_W > RMQ_IN_W) ? ROOT_W : RMQ_IN_W;

    logic en;

    // ---------------- stage 1: trace and largest diagonal element ----------------
    logic                         r1_vld;
    logic signed [RMQ_IN_W-1:0]   r1_m [9];
    logic signed [TR_W-1:0]       r1_tr;
    logic                         r1_pos;
    logic [1:0]                   r1_i;
    logic signed [TR_W-1:0]       n1_tr;
    logic                         n1_c1, n1_c2;
    logic signed [RMQ_IN_W-1:0]   n1_dmax;

    always_comb begin
        n1_tr   = TR_W'(i_m00) + TR_W'(i_m11) + TR_W'(i_m22);
        n1_c1   = (i_m11 > i_m00);               // ties keep the lower index
        n1_dmax = n1_c1 ? i_m11 : i_m00;
        n1_c2   = (i_m22 > n1_dmax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m[0] <= i_m00;
            r1_m[1] <= i_m01;
            r1_m[2] <= i_m02;
            r1_m[3] <= i_m10;
            r1_m[4] <= i_m11;
            r1_m[5] <= i_m12;
            r1_m[6] <= i_m20;
            r1_m[7] <= i_m21;
            r1_m[8] <= i_m22;
            r1_tr   <= n1_tr;
            r1_pos  <= (n1_tr > 0);              // zero trace takes the diagonal branch
            r1_i    <= n1_c2 ? SEL_I2 : (n1_c1 ? SEL_I1 : SEL_I0);
        end
    end

    // ---------------- stage 2: radicand and the three numerators -----------------
    t_ctl                        r2_ctl;
    logic [RAD_W-1:0]            r2_rad;
    logic [2:0][RMQ_NUM_W-1:0]   r2_num;
    logic [1:0]                  n2_sel;
    logic signed [TR_W-1:0]      n2_base;
    logic signed [RS_W-1:0]      n2_rs;
    logic signed [RMQ_NUM_W-1:0] d12, d20, d01, a01, a02, a12;
    logic [2:0][RMQ_NUM_W-1:0]   n2_num;

    always_comb begin
        n2_sel = r1_pos ? SEL_TRACE : r1_i;
        d12 = {r1_m[5][RMQ_IN_W-1], r1_m[5]} - {r1_m[7][RMQ_IN_W-1], r1_m[7]};
        d20 = {r1_m[6][RMQ_IN_W-1], r1_m[6]} - {r1_m[2][RMQ_IN_W-1], r1_m[2]};
        d01 = {r1_m[1][RMQ_IN_W-1], r1_m[1]} - {r1_m[3][RMQ_IN_W-1], r1_m[3]};
        a01 = {r1_m[1][RMQ_IN_W-1], r1_m[1]} + {r1_m[3][RMQ_IN_W-1], r1_m[3]};
        a02 = {r1_m[2][RMQ_IN_W-1], r1_m[2]} + {r1_m[6][RMQ_IN_W-1], r1_m[6]};
        a12 = {r1_m[5][RMQ_IN_W-1], r1_m[5]} + {r1_m[7][RMQ_IN_W-1], r1_m[7]};
        // lane 0 feeds w in the diagonal branches; lanes 1 and 2 feed q[j] and q[k]
        unique case (n2_sel)
            SEL_I0: begin
                n2_base = TR_W'(r1_m[0]) - TR_W'(r1_m[4]) - TR_W'(r1_m[8]);
                n2_num  = {a02, a01, d12};
            end
            SEL_I1: begin
                n2_base = TR_W'(r1_m[4]) - TR_W'(r1_m[8]) - TR_W'(r1_m[0]);
                n2_num  = {a01, a12, d20};
            end
            SEL_I2: begin
                n2_base = TR_W'(r1_m[8]) - TR_W'(r1_m[0]) - TR_W'(r1_m[4]);
                n2_num  = {a12, a02, d01};
            end
            default: begin
                n2_base = r1_tr;
                n2_num  = {d01, d20, d12};
            end
        endcase
        n2_rs = RS_W'(n2_base) + (RS_W'(1) <<< FRAC_BITS);
        // radicand below one lsb is clamped to one lsb
        if (n2_rs < RS_W'(1)) begin
            n2_rs = RS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (en) begin
            r2_ctl <= '{vld: r1_vld, sel: n2_sel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rad <= n2_rs[RAD_W-1:0];
            r2_num <= n2_num;
        end
    end

    // ---------------- square root and dividers ----------------
    t_ctl                       sq_ctl;
    logic [ROOT_W-1:0]          sq_root;
    logic [2:0][RMQ_NUM_W-1:0]  sq_num;
    t_ctl                       dv_ctl;
    logic [ROOT_W-1:0]          dv_root;
    logic [2:0]                 dv_neg;
    logic [2:0][QUO_W-1:0]      dv_quo;

    rmq_sqrt_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r2_ctl),
        .i_rad   (r2_rad),
        .i_num   (r2_num),
        .o_ctl   (sq_ctl),
        .o_root  (sq_root),
        .o_num   (sq_num)
    );

    rmq_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (sq_ctl),
        .i_root  (sq_root),
        .i_num   (sq_num),
        .o_ctl   (dv_ctl),
        .o_root  (dv_root),
        .o_neg   (dv_neg),
        .o_quo   (dv_quo)
    );

    // ---------------- final stage: saturation and component placement ----------------
    function automatic logic [RMQ_IN_W-1:0] f_sat(input logic neg, input logic [QUO_W-1:0] q);
        logic [RMQ_IN_W-1:0] res;
        if (neg) begin
            res = (q > QUO_W'(RMQ_Q_MIN_MAG)) ? RMQ_IN_W'(RMQ_Q_MIN_MAG)
                                              : (~q[RMQ_IN_W-1:0] + 1'b1);
        end else begin
            res = (q > QUO_W'(RMQ_Q_MAX)) ? RMQ_IN_W'(RMQ_Q_MAX) : q[RMQ_IN_W-1:0];
        end
        return res;
    endfunction

    logic                       rf_vld;
    logic [3:0][RMQ_IN_W-1:0]   rf_q;         // x, y, z, w in slots 0..3
    logic [HALF_W-1:0]          nf_half;
    logic [RMQ_IN_W-1:0]        nf_h;
    logic [RMQ_IN_W-1:0]        nf_s0, nf_s1, nf_s2;
    logic [3:0][RMQ_IN_W-1:0]   nf_q;

    always_comb begin
        nf_half = HALF_W'(dv_root >> 1);
        nf_h    = (nf_half > HALF_W'(RMQ_Q_MAX)) ? RMQ_IN_W'(RMQ_Q_MAX)
                                                 : nf_half[RMQ_IN_W-1:0];
        nf_s0   = f_sat(dv_neg[0], dv_quo[0]);
        nf_s1   = f_sat(dv_neg[1], dv_quo[1]);
        nf_s2   = f_sat(dv_neg[2], dv_quo[2]);
        unique case (dv_ctl.sel)
            SEL_I0:  nf_q = {nf_s0, nf_s2, nf_s1, nf_h};
            SEL_I1:  nf_q = {nf_s0, nf_s1, nf_h, nf_s2};
            SEL_I2:  nf_q = {nf_s0, nf_h, nf_s2, nf_s1};
            default: nf_q = {nf_h, nf_s2, nf_s1, nf_s0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_vld <= 1'b0;
        end else if (en) begin
            rf_vld <= dv_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rf_q <= nf_q;
        end
    end

    // ---------------- output register and skid register ----------------
    logic                       r_out_vld;
    logic [3:0][RMQ_IN_W-1:0]   r_out_q;
    logic                       r_skid_vld;
    logic [3:0][RMQ_IN_W-1:0]   r_skid_q;
    logic                       out_free;

    // whole pipe moves together; it stops only when the skid register holds a beat
    assign en = !r_skid_vld;

    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (r_skid_vld) begin
                // pipe is frozen; drain the skid beat first
                if (out_free) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (rf_vld) begin
                if (out_free) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) begin
                r_out_q <= r_skid_q;
            end
        end else if (rf_vld) begin
            if (out_free) begin
                r_out_q <= rf_q;
            end else begin
                r_skid_q <= rf_q;
            end
        end
    end

    assign o_stall = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_qx    = r_out_q[0];
    assign o_qy    = r_out_q[1];
    assign o_qz    = r_out_q[2];
    assign o_qw    = r_out_q[3];

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall && rf_vld))
        else $error("skid register filled without a stalled output beat");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall && !r_skid_vld && rf_vld) |=> r_skid_vld)
        else $error("finished beat lost while output stalled");

endmodule
